// ===== rtl/core/mf33_pkg.sv =====
`default_nettype none
package mf33_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4095;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  // 3x3 window
  localparam int WIN_SIDE   = 3;
  localparam int WIN_N      = 9;
  localparam int CENTER_IDX = 4;

  // Derived counter widths
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int W_W       = $clog2(MAX_WIDTH + 1);
  localparam int COL_W     = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W     = FH_W;
  localparam int POS_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int K_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int DIV_CNT_W = $clog2(POS_W + 1);

  // Reset geometry
  localparam int RESET_EFF_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam logic [FW_W-1:0]  RESET_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0]  RESET_HEIGHT = FH_W'(480);
  localparam logic [POS_W-1:0] RESET_TOTAL  = POS_W'(RESET_EFF_W * 480);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Request kind carried on tuser
  localparam logic REQ_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef enum logic [2:0] {
    CAL_IDLE,
    CAL_TOTAL,
    CAL_NORM,
    CAL_K,
    CAL_KADD,
    CAL_DIV
  } cal_state_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [W_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] quo;
    logic [W_W-1:0]   rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/mf33_line_buf.sv =====
`default_nettype none
module mf33_line_buf (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [mf33_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [mf33_pkg::PIX_W-1:0]    wdata,
  input  wire logic [mf33_pkg::ADDR_W-1:0]   raddr,
  output logic      [mf33_pkg::PIX_W-1:0]    rdata
);
  import mf33_pkg::*;

  pix_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mf33_div.sv =====
`default_nettype none
module mf33_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mf33_pkg::div_req_t req,
  output mf33_pkg::div_rsp_t      rsp
);
  import mf33_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [POS_W-1:0]     quo;
  logic [W_W-1:0]       rem;
  logic [W_W-1:0]       divisor;
  logic [W_W:0]         rem_shift;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_shift = {rem, quo[POS_W-1]};
    fits      = (rem_shift >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(POS_W);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[POS_W-2:0], fits};
      if (fits) begin
        rem <= W_W'(rem_shift - {1'b0, divisor});
      end else begin
        rem <= rem_shift[W_W-1:0];
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== rtl/core/mf33_median9.sv =====
`default_nettype none
module mf33_median9 (
  input  wire mf33_pkg::win_t             win,
  output logic [mf33_pkg::PIX_W-1:0]      med
);
  import mf33_pkg::*;

  pix_t lo  [WIN_SIDE];
  pix_t mid [WIN_SIDE];
  pix_t hi  [WIN_SIDE];

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t pmed3(input pix_t a, input pix_t b, input pix_t c);
    return pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

  // sort each row, then max of lows, median of mids, min of highs
  always_comb begin
    for (int r = 0; r < WIN_SIDE; r++) begin
      lo[r]  = pmin(pmin(win[WIN_SIDE*r], win[WIN_SIDE*r+1]), win[WIN_SIDE*r+2]);
      mid[r] = pmed3(win[WIN_SIDE*r], win[WIN_SIDE*r+1], win[WIN_SIDE*r+2]);
      hi[r]  = pmax(pmax(win[WIN_SIDE*r], win[WIN_SIDE*r+1]), win[WIN_SIDE*r+2]);
    end
    med = pmed3(pmax(pmax(lo[0], lo[1]), lo[2]),
                pmed3(mid[0], mid[1], mid[2]),
                pmin(pmin(hi[0], hi[1]), hi[2]));
  end

endmodule
`default_nettype wire

// ===== rtl/core/median_filter_3x3_unit.sv =====
// 3x3 median filter for a raster stream of 8-bit grey pixels. One item is
// taken per clock while s_tready is high: each transfer updates the counters,
// the two line stores and the 3x3 window in that same cycle, and a released
// result passes through the result stage into the output register, so the
// block sustains one pixel per clock unless stalled; the line stores are
// single-write, single-read stores with a registered read of the next column.
// Interior pixels get the median of their 3x3 neighborhood, pixels in the
// first or last row or column pass through. A result comes out frame_width+1
// items after its pixel, so after the last pixel of a frame the source sends
// drain items (tuser = 1) until the result with tlast arrives; a drain sent
// while the frame is still being fed is dropped. After every configuration
// write the block recomputes its frame size and output position and holds
// s_tready low until the serial divider, one bit per cycle, has finished.
`default_nettype none
module median_filter_3x3_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [mf33_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel_in
  input  wire logic [0:0]                        s_tuser,   // [0] req_type
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [mf33_pkg::PIX_W-1:0]             m_tdata,   // [7:0] pixel_out
  output logic                                   m_tlast,   // frame_last
  input  wire logic                              cfg_we,
  input  wire logic [mf33_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mf33_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mf33_pkg::*;

  // configuration and effective geometry
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [W_W-1:0]   w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] w_col;

  cal_state_t cal, cal_next;

  // working counters (used by the datapath)
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [K_W-1:0]    k, k_next;
  logic [ROW_W-1:0]  orow, orow_next;
  logic [ADDR_W-1:0] ocol, ocol_next;
  logic [POS_W-1:0]  total, total_next;

  // committed counters: state as left by the last transfer, source of
  // every recalculation
  logic [COL_W-1:0]  col_o;
  logic [ROW_W-1:0]  row_o;
  logic [POS_W-1:0]  pos_o;

  // counters normalized for the current geometry
  logic [COL_W-1:0]  norm_col;
  logic [ROW_W-1:0]  norm_row;
  logic [POS_W-1:0]  norm_pos;

  win_t win;
  pix_t up_rd, mid_rd, px_eff, med;

  logic fed, drain, acc, act, lwe;
  logic emit_hit, last_hit, inner_hit;
  logic b_valid, b_inner, b_last, b_adv;
  logic [ADDR_W-1:0] c_cur, c_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // width 0 acts as 1, above the line store size it is clamped; height 0 acts as 1
  always_comb begin
    if (frame_width == '0) begin
      w_eff = W_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(frame_width);
    end
    h_eff = (frame_height == '0) ? ROW_W'(1) : frame_height;
    w_col = COL_W'(w_eff);
  end

  // fed: every pixel of the frame is in, further items only push results
  assign fed    = (row >= h_eff);
  assign drain  = (s_tuser[0] == REQ_DRAIN);
  assign acc    = s_tvalid && s_tready;
  assign act    = acc && !(drain && !fed);
  assign lwe    = act && !fed;
  assign px_eff = fed ? '0 : s_tdata;

  assign c_cur  = (col < w_col) ? col[ADDR_W-1:0] : '0;
  assign c_next = (col_next < w_col) ? col_next[ADDR_W-1:0] : '0;

  // a result is due once the input is frame_width+1 positions ahead
  assign emit_hit = (k >= (K_W'(pos) + K_W'(w_eff) + K_W'(1)));
  assign last_hit = (({1'b0, pos} + (POS_W + 1)'(1)) >= {1'b0, total});
  assign inner_hit = (orow != '0) &&
                     (((ROW_W + 1)'(orow) + (ROW_W + 1)'(2)) <= (ROW_W + 1)'(h_eff)) &&
                     (ocol != '0) &&
                     (((W_W + 1)'(ocol) + (W_W + 1)'(2)) <= (W_W + 1)'(w_eff));

  // result stage: b_* holds the flags of a released result, the median (or the
  // centre pixel off the interior) goes from the window into the output register
  assign b_adv    = !m_tvalid || m_tready;
  assign s_tready = (cal == CAL_IDLE) && !cfg_we && (!b_valid || b_adv);

  // normalization after a geometry change
  always_comb begin
    norm_col = col_o;
    norm_row = row_o;
    norm_pos = pos_o;
    if (pos_o >= total) begin
      norm_col = '0;
      norm_row = '0;
      norm_pos = '0;
    end else begin
      if (row_o > h_eff) begin
        norm_row = h_eff;
      end
      if ((norm_row < h_eff) && (col_o >= w_col)) begin
        norm_col = '0;
        norm_row = norm_row + ROW_W'(1);
      end
    end
  end

  assign div_req.start    = (cal == CAL_NORM);
  assign div_req.dividend = norm_pos;
  assign div_req.divisor  = w_eff;

  // counter update per transfer, and the recalculation sequence
  always_comb begin
    cal_next   = cal;
    col_next   = col;
    row_next   = row;
    pos_next   = pos;
    k_next     = k;
    orow_next  = orow;
    ocol_next  = ocol;
    total_next = total;
    case (cal)
      CAL_IDLE: begin
        if (act) begin
          if (!fed) begin
            k_next = k + K_W'(1);
            if ((col + COL_W'(1)) >= w_col) begin
              col_next = '0;
              row_next = row + ROW_W'(1);
            end else begin
              col_next = col + COL_W'(1);
            end
          end else if (col < COL_W'(MAX_WIDTH + 1)) begin
            col_next = col + COL_W'(1);
            k_next   = k + K_W'(1);
          end
          if (emit_hit) begin
            if (last_hit) begin
              // frame done: restart for the next one
              col_next  = '0;
              row_next  = '0;
              pos_next  = '0;
              k_next    = '0;
              orow_next = '0;
              ocol_next = '0;
            end else begin
              pos_next = pos + POS_W'(1);
              if ((W_W'(ocol) + W_W'(1)) == w_eff) begin
                ocol_next = '0;
                orow_next = orow + ROW_W'(1);
              end else begin
                ocol_next = ocol + ADDR_W'(1);
              end
            end
          end
        end
      end
      CAL_TOTAL: begin
        total_next = POS_W'(w_eff) * POS_W'(h_eff);
        cal_next   = CAL_NORM;
      end
      CAL_NORM: begin
        col_next = norm_col;
        row_next = norm_row;
        pos_next = norm_pos;
        cal_next = CAL_K;
      end
      CAL_K: begin
        k_next   = K_W'(row) * K_W'(w_eff);
        cal_next = CAL_KADD;
      end
      CAL_KADD: begin
        k_next   = k + K_W'(col);
        cal_next = CAL_DIV;
      end
      CAL_DIV: begin
        if (!div_rsp.busy) begin
          orow_next = div_rsp.quo[ROW_W-1:0];
          ocol_next = div_rsp.rem[ADDR_W-1:0];
          cal_next  = CAL_IDLE;
        end
      end
      default: begin
        cal_next = CAL_IDLE;
      end
    endcase
    // any register write restarts the sequence
    if (cfg_we) begin
      cal_next = CAL_TOTAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal          <= CAL_IDLE;
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      col          <= '0;
      row          <= '0;
      pos          <= '0;
      k            <= '0;
      orow         <= '0;
      ocol         <= '0;
      total        <= RESET_TOTAL;
      col_o        <= '0;
      row_o        <= '0;
      pos_o        <= '0;
      win          <= '0;
      b_valid      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      cal   <= cal_next;
      col   <= col_next;
      row   <= row_next;
      pos   <= pos_next;
      k     <= k_next;
      orow  <= orow_next;
      ocol  <= ocol_next;
      total <= total_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        col_o <= col_next;
        row_o <= row_next;
        pos_o <= pos_next;
      end
      // window slides one column; right column comes from the line stores and the pixel
      if (act) begin
        for (int r = 0; r < WIN_SIDE; r++) begin
          win[WIN_SIDE*r]   <= win[WIN_SIDE*r+1];
          win[WIN_SIDE*r+1] <= win[WIN_SIDE*r+2];
        end
        win[WIN_SIDE-1]         <= up_rd;
        win[2*WIN_SIDE-1]       <= mid_rd;
        win[WIN_N-1]            <= px_eff;
      end
      if (act && emit_hit) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_valid && b_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act && emit_hit) begin
      b_inner <= inner_hit;
      b_last  <= last_hit;
    end
    if (b_valid && b_adv) begin
      m_tdata <= b_inner ? med : win[CENTER_IDX];
      m_tlast <= b_last;
    end
  end

  // upper line gets what the middle line held, middle line gets the pixel
  mf33_line_buf u_upper (
    .clk   (clk),
    .we    (lwe),
    .waddr (c_cur),
    .wdata (mid_rd),
    .raddr (c_next),
    .rdata (up_rd)
  );

  mf33_line_buf u_middle (
    .clk   (clk),
    .we    (lwe),
    .waddr (c_cur),
    .wdata (px_eff),
    .raddr (c_next),
    .rdata (mid_rd)
  );

  mf33_median9 u_med (
    .win (win),
    .med (med)
  );

  mf33_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input taken right after a register write");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (cal == CAL_IDLE) |-> (pos < total))
    else $error("output position beyond frame size");

  a_ocol_in_row: assert property (@(posedge clk) disable iff (rst)
    (cal == CAL_IDLE) |-> (W_W'(ocol) < w_eff))
    else $error("output column beyond frame width");

  a_k_consistent: assert property (@(posedge clk) disable iff (rst)
    (cal == CAL_IDLE) |-> (k == (K_W'(row) * K_W'(w_eff) + K_W'(col))))
    else $error("input position out of step with row and column");

  a_window_frozen: assert property (@(posedge clk) disable iff (rst)
    (b_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("window may move under a pending result");

endmodule
`default_nettype wire
